// ===== rtl/binary_heap_priority_queue_top_macros.svh =====
// Assertion macros for the binary heap priority queue.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BHPQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bhpq check failed");
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bhpq check failed");
`else
`define BHPQ_ASSERT_SAME(label, ante, cons)
`define BHPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/bhpq_pkg.sv =====
// Shared types and codes of the binary heap priority queue.
package bhpq_pkg;

	localparam int FIELD_BITS = 32;
	localparam int COUNT_BITS = 7;

	localparam logic [1:0] K_PUSH   = 2'd0;
	localparam logic [1:0] K_POP    = 2'd1;
	localparam logic [1:0] K_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]            kind;
		logic [FIELD_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FIELD_BITS-1:0] taken_value;
		logic [FIELD_BITS-1:0] top_value;
		logic [COUNT_BITS-1:0] count;
		logic                  is_empty;
	} res_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} cell_ctl_t;

endpackage

// ===== rtl/bhpq_level_cell.sv =====
// One heap level: its entries, a write port, a paired read port and a link in the read chain.
module bhpq_level_cell #(
	parameter int LVL = 0,
	parameter int NB  = 7,
	parameter int VB  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bhpq_pkg::cell_ctl_t ctl,
	input  logic [NB-1:0]       rd_node,
	input  logic [NB-1:0]       wr_node,
	input  logic [VB-1:0]       wr_data,
	input  logic [VB-1:0]       chain_a_in,
	input  logic [VB-1:0]       chain_b_in,
	output logic [VB-1:0]       chain_a_out,
	output logic [VB-1:0]       chain_b_out
);
	import bhpq_pkg::*;

	logic          rd_hit;
	logic          wr_hit;
	logic          hit_q;
	logic [VB-1:0] a_q;
	logic [VB-1:0] b_q;

	// A node number belongs to this level when its leading one sits at bit LVL.
	assign rd_hit = ctl.rd_en && ((rd_node >> LVL) == NB'(1));
	assign wr_hit = ctl.wr_en && ((wr_node >> LVL) == NB'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.rd_en) begin
			hit_q <= rd_hit;
		end
	end

	generate
		if (LVL == 0) begin : g_root
			logic [VB-1:0] ent_q;
			always_ff @(posedge clk) begin
				if (wr_hit) begin
					ent_q <= wr_data;
				end
				if (rd_hit) begin
					a_q <= ent_q;
					b_q <= ent_q;
				end
			end
		end else begin : g_mem
			logic [VB-1:0]  mem [2**LVL];
			logic [LVL-1:0] rd_off;
			logic [LVL-1:0] wr_off;
			assign rd_off = rd_node[LVL-1:0];
			assign wr_off = wr_node[LVL-1:0];
			// The second read port returns the right sibling of the addressed left child.
			always_ff @(posedge clk) begin
				if (wr_hit) begin
					mem[wr_off] <= wr_data;
				end
				if (rd_hit) begin
					a_q <= mem[rd_off];
					b_q <= mem[rd_off | LVL'(1)];
				end
			end
		end
	endgenerate

	assign chain_a_out = hit_q ? a_q : chain_a_in;
	assign chain_b_out = hit_q ? b_q : chain_b_in;

endmodule

// ===== rtl/binary_heap_priority_queue_top.sv =====
// Top level of the binary heap priority queue: sequencer and the chain of level cells.
//
// Usage: a command transaction (push, pop top, remove matching value) is taken on
// the cmd port at a rising edge where start is high and busy is low. Busy then stays
// high until the result transaction has been shown. The result appears on the result
// port for exactly one cycle, marked by done; the receiver cannot stall it, so it must
// capture the result in that cycle. Busy falls in the cycle after done.
// Sequence: a push climbs the heap level by level; a pop takes the root and descends
// level by level; a remove scans one stored entry per cycle, then sifts down and up,
// level by level each. A new command is not taken before the last one is done. The
// pace is set by the single read port shared by the level cells: the heap is one node
// deep per read, and the scan reads one entry a cycle.
// The order register is written on the cfg channel (cfg_valid, always ready); write it
// only while the block is idle. Bit 0 set keeps the smallest value on top, clear keeps
// the largest. Reset empties the queue and selects largest-on-top; the stored
// entries themselves are not cleared, since only entries up to the count are read.
`include "binary_heap_priority_queue_top_macros.svh"
module binary_heap_priority_queue_top #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bhpq_pkg::cmd_t cmd,
	output logic           done,
	output bhpq_pkg::res_t result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	import bhpq_pkg::*;

	// Nodes are numbered from 1 at the root; a node's level is the place of its leading one.
	localparam int NB = $clog2(DEPTH + 1);
	localparam int NL = NB;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_POP_ROOT = 12'b000000000010,
		S_SCAN     = 12'b000000000100,
		S_LAST     = 12'b000000001000,
		S_DN_RD    = 12'b000000010000,
		S_DN_CMP   = 12'b000000100000,
		S_RE_RD    = 12'b000001000000,
		S_RE_LD    = 12'b000010000000,
		S_UP_RD    = 12'b000100000000,
		S_UP_CMP   = 12'b001000000000,
		S_TOP      = 12'b010000000000,
		S_DONE     = 12'b100000000000
	} state_t;

	function automatic logic ranks(input logic mode, input logic [VALUE_BITS-1:0] a,
		input logic [VALUE_BITS-1:0] b);
		return mode ? (a < b) : (a > b);
	endfunction

	state_t                state_q;
	logic [NB-1:0]         count_q;
	logic                  order_q;
	logic [1:0]            kind_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] cur_q;
	logic [VALUE_BITS-1:0] taken_q;
	logic [1:0]            status_q;
	logic [NB-1:0]         node_q;
	logic [NB-1:0]         rm_q;
	logic [NB:0]           issue_q;
	logic                  pend_q;
	logic [NB-1:0]         rdn_q;

	logic [VALUE_BITS-1:0] in_val;
	logic [VALUE_BITS-1:0] rdata_a;
	logic [VALUE_BITS-1:0] rdata_b;
	cell_ctl_t             ctl;
	logic [NB-1:0]         rd_node;
	logic [NB-1:0]         wr_node;
	logic [VALUE_BITS-1:0] wr_data;

	logic [NB:0]           kid;
	logic [NB:0]           count_x;
	logic                  has_l;
	logic                  has_r;
	logic                  pick_l;
	logic                  pick_r;
	logic [VALUE_BITS-1:0] best_val;
	logic [NB-1:0]         best_node;
	logic                  scan_hit;
	logic                  scan_more;
	logic                  up_move;

	logic [VALUE_BITS-1:0] chain_a [NL+1];
	logic [VALUE_BITS-1:0] chain_b [NL+1];

	assign in_val = VALUE_BITS'(cmd.value);

	// Read chain: each level cell passes on its neighbor's data unless it answered itself.
	assign chain_a[0] = '0;
	assign chain_b[0] = '0;
	generate
		for (genvar g = 0; g < NL; g++) begin : g_lvl
			bhpq_level_cell #(
				.LVL(g),
				.NB (NB),
				.VB (VALUE_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.rd_node    (rd_node),
				.wr_node    (wr_node),
				.wr_data    (wr_data),
				.chain_a_in (chain_a[g]),
				.chain_b_in (chain_b[g]),
				.chain_a_out(chain_a[g+1]),
				.chain_b_out(chain_b[g+1])
			);
		end
	endgenerate
	assign rdata_a = chain_a[NL];
	assign rdata_b = chain_b[NL];

	// Sift-down decision: the moving value against the children read last cycle.
	assign kid     = {node_q, 1'b0};
	assign count_x = {1'b0, count_q};
	assign has_l   = kid <= count_x;
	assign has_r   = {node_q, 1'b1} <= count_x;
	assign pick_l  = ranks(order_q, rdata_a, cur_q);

	always_comb begin
		best_val  = pick_l ? rdata_a : cur_q;
		best_node = pick_l ? kid[NB-1:0] : node_q;
		pick_r    = has_r && ranks(order_q, rdata_b, best_val);
		if (pick_r) begin
			best_val  = rdata_b;
			best_node = kid[NB-1:0] | NB'(1);
		end
	end

	// The scan compares the entry read last cycle while the next read goes out.
	assign scan_hit  = pend_q && (rdata_a == val_q);
	assign scan_more = issue_q <= count_x;
	assign up_move   = ranks(order_q, cur_q, rdata_a);

	// Requests to the level cells.
	always_comb begin
		ctl     = '0;
		rd_node = node_q;
		wr_node = node_q;
		wr_data = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && cmd.kind == K_POP && count_q != '0) begin
					ctl.rd_en = 1'b1;
					rd_node   = NB'(1);
				end
			end
			S_POP_ROOT: begin
				if (count_q != NB'(1)) begin
					ctl.rd_en = 1'b1;
					rd_node   = count_q;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					if (rdn_q < count_q) begin
						ctl.rd_en = 1'b1;
						rd_node   = count_q;
					end
				end else if (scan_more) begin
					ctl.rd_en = 1'b1;
					rd_node   = issue_q[NB-1:0];
				end
			end
			S_LAST: begin
			end
			S_DN_RD: begin
				if (has_l) begin
					ctl.rd_en = 1'b1;
					rd_node   = kid[NB-1:0];
				end else begin
					ctl.wr_en = 1'b1;
				end
			end
			S_DN_CMP: begin
				ctl.wr_en = 1'b1;
				wr_data   = best_val;
			end
			S_RE_RD: begin
				ctl.rd_en = 1'b1;
				rd_node   = rm_q;
			end
			S_RE_LD: begin
			end
			S_UP_RD: begin
				if (node_q == NB'(1)) begin
					ctl.wr_en = 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
					rd_node   = node_q >> 1;
				end
			end
			S_UP_CMP: begin
				ctl.wr_en = 1'b1;
				wr_data   = up_move ? rdata_a : cur_q;
			end
			S_TOP: begin
				ctl.rd_en = 1'b1;
				rd_node   = NB'(1);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Order register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid) begin
			order_q <= cfg_data;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.kind)
							K_PUSH: begin
								if (count_q == NB'(DEPTH)) begin
									state_q <= S_TOP;
								end else begin
									count_q <= count_q + NB'(1);
									state_q <= S_UP_RD;
								end
							end
							K_POP: begin
								state_q <= (count_q == '0) ? S_TOP : S_POP_ROOT;
							end
							K_REMOVE: begin
								pend_q  <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_TOP;
							end
						endcase
					end
				end
				S_POP_ROOT: begin
					count_q <= count_q - NB'(1);
					state_q <= (count_q == NB'(1)) ? S_TOP : S_LAST;
				end
				S_SCAN: begin
					if (scan_hit) begin
						count_q <= count_q - NB'(1);
						pend_q  <= 1'b0;
						state_q <= (rdn_q < count_q) ? S_LAST : S_TOP;
					end else if (scan_more) begin
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_TOP;
					end
				end
				S_LAST: begin
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (has_l) begin
						state_q <= S_DN_CMP;
					end else begin
						state_q <= (kind_q == K_REMOVE) ? S_RE_RD : S_TOP;
					end
				end
				S_DN_CMP: begin
					if (best_node == node_q) begin
						state_q <= (kind_q == K_REMOVE) ? S_RE_RD : S_TOP;
					end else begin
						state_q <= S_DN_RD;
					end
				end
				S_RE_RD: begin
					state_q <= S_RE_LD;
				end
				S_RE_LD: begin
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					state_q <= (node_q == NB'(1)) ? S_TOP : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= up_move ? S_UP_RD : S_TOP;
				end
				S_TOP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the operation in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q   <= cmd.kind;
					val_q    <= in_val;
					taken_q  <= '0;
					status_q <= ST_OK;
					issue_q  <= (NB+1)'(1);
					node_q   <= count_q + NB'(1);
					cur_q    <= in_val;
					case (cmd.kind)
						K_PUSH: begin
							if (count_q == NB'(DEPTH)) begin
								status_q <= ST_FULL;
							end
						end
						K_POP: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP_ROOT: begin
				taken_q <= rdata_a;
				node_q  <= NB'(1);
			end
			S_SCAN: begin
				if (scan_hit) begin
					taken_q <= val_q;
					rm_q    <= rdn_q;
					node_q  <= rdn_q;
				end else if (scan_more) begin
					rdn_q   <= issue_q[NB-1:0];
					issue_q <= issue_q + (NB+1)'(1);
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_LAST: begin
				cur_q <= rdata_a;
			end
			S_DN_CMP: begin
				node_q <= best_node;
			end
			S_RE_RD: begin
				node_q <= rm_q;
			end
			S_RE_LD: begin
				cur_q <= rdata_a;
			end
			S_UP_CMP: begin
				if (up_move) begin
					node_q <= node_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = state_q != S_IDLE;
	assign done      = state_q == S_DONE;
	assign cfg_ready = 1'b1;

	// The root was read in the cycle before the result is shown.
	assign result.status      = status_q;
	assign result.taken_value = FIELD_BITS'(taken_q);
	assign result.top_value   = (count_q != '0) ? FIELD_BITS'(rdata_a) : '0;
	assign result.count       = COUNT_BITS'(count_q);
	assign result.is_empty    = count_q == '0;

	`BHPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= NB'(DEPTH))
	`BHPQ_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`BHPQ_ASSERT_NEXT(a_done_idle, done, !busy)
	`BHPQ_ASSERT_SAME(a_full_count, done && result.status == ST_FULL, count_q == NB'(DEPTH))

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the binary heap priority queue with a heap-mirroring scoreboard.
`timescale 1ns / 100ps
module testbench;
	import bhpq_pkg::*;

	localparam int HEAP_DEPTH = 64;
	localparam int VALUE_W = 32;
	localparam int RANDOM_ITEMS = 1525;
	localparam int CYCLE_LIMIT = 1000000;
	// The worst remove finishes well within this, so it covers the tail of the run.
	localparam int DRAIN_CYCLES = 120;
	localparam int MAX_REPORTS = 10;

	// The fourth kind code has no name in the package; the block ignores it.
	localparam logic [1:0] K_IGNORED = 2'd3;

	localparam bit ORDER_LARGEST = 1'b0;
	localparam bit ORDER_SMALLEST = 1'b1;

	typedef enum int {
		EP_FILL,
		EP_DRAIN,
		EP_MIXED
	} episode_t;

	// The scoreboard keeps its own copy of the heap and works out the reply to
	// each accepted command transaction, then matches replies in order.
	class heap_mirror;
		logic [VALUE_W-1:0] slots [HEAP_DEPTH];
		int unsigned fill;
		bit smallest_on_top;
		res_t due_results [$];
		int unsigned failures;
		int unsigned peak_fill;
		int unsigned status_seen [4];

		function new();
			fill = 0;
			smallest_on_top = ORDER_LARGEST;
			failures = 0;
			peak_fill = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void set_order(bit smallest);
			smallest_on_top = smallest;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// True when a belongs above b under the current ordering.
		function bit outranks(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
			return smallest_on_top ? (a < b) : (a > b);
		endfunction

		function void swap_slots(int unsigned i, int unsigned j);
			logic [VALUE_W-1:0] t;
			t = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		endfunction

		function void climb(int unsigned pos);
			while (pos > 0 && outranks(slots[pos], slots[(pos - 1) / 2])) begin
				swap_slots(pos, (pos - 1) / 2);
				pos = (pos - 1) / 2;
			end
		endfunction

		// Standard sift-down: move to the better child while it outranks the parent.
		// Equal values never swap.
		function void descend(int unsigned pos);
			int unsigned kid;
			int unsigned best;
			bit moving;
			moving = 1'b1;
			while (moving && pos < fill) begin
				best = pos;
				kid = 2 * pos + 1;
				if (kid < fill && outranks(slots[kid], slots[best]))
					best = kid;
				if (kid + 1 < fill && outranks(slots[kid + 1], slots[best]))
					best = kid + 1;
				if (best == pos) begin
					moving = 1'b0;
				end else begin
					swap_slots(pos, best);
					pos = best;
				end
			end
		endfunction

		// Any value currently stored; only called with a nonempty heap.
		function logic [VALUE_W-1:0] any_stored();
			return slots[$urandom_range(fill - 1)];
		endfunction

		function void note_command(cmd_t c);
			res_t r;
			int unsigned idx;
			r = '0;
			r.status = ST_OK;
			case (c.kind)
				K_PUSH: begin
					if (fill >= HEAP_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slots[fill] = c.value;
						fill++;
						climb(fill - 1);
					end
				end
				K_POP: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.taken_value = slots[0];
						fill--;
						if (fill > 0) begin
							slots[0] = slots[fill];
							descend(0);
						end
					end
				end
				K_REMOVE: begin
					// Linear scan from the root; the first equal entry is taken.
					idx = 0;
					while (idx < fill && slots[idx] != c.value)
						idx++;
					if (idx >= fill) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.taken_value = slots[idx];
						fill--;
						// The last slot is just dropped; any other gets the last entry,
						// which may have to move either way.
						if (idx < fill) begin
							slots[idx] = slots[fill];
							descend(idx);
							climb(idx);
						end
					end
				end
				default: begin
				end
			endcase
			r.top_value = (fill > 0) ? slots[0] : '0;
			r.count = fill[COUNT_BITS-1:0];
			r.is_empty = (fill == 0);
			if (fill > peak_fill)
				peak_fill = fill;
			due_results.push_back(r);
		endfunction

		function void compare(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
			if (got !== want)
				flag($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				flag($sformatf("result with nothing outstanding (status %0d, count %0d)",
					got.status, got.count));
				return;
			end
			want = due_results.pop_front();
			status_seen[want.status]++;
			compare("status", want.status, got.status);
			compare("taken_value", want.taken_value, got.taken_value);
			compare("top_value", want.top_value, got.top_value);
			compare("count", want.count, got.count);
			compare("is_empty", want.is_empty, got.is_empty);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	heap_mirror mirror;
	int unsigned cycles;
	int unsigned gap_pct;
	int unsigned kinds_sent [4];
	int unsigned order_writes;

	binary_heap_priority_queue_top #(
		.DEPTH(HEAP_DEPTH),
		.VALUE_BITS(VALUE_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Results last one cycle and cannot be stalled, so every done is taken at the
	// rising edge that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_result(result);
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				mirror.due_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// All driver tasks start and return just after a falling edge, where the
	// inputs of the block are changed.
	task automatic send_cmd(cmd_t c);
		cmd_t junk;
		// Random idle cycles with start low; the command lines carry noise meanwhile.
		while ($urandom_range(99) < gap_pct) begin
			junk.kind = 2'($urandom_range(3));
			junk.value = $urandom;
			start = 1'b0;
			cmd = junk;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		// Start may sit high through a busy stretch; the transaction happens at the
		// first rising edge that sees busy low.
		do
			@(posedge clk);
		while (busy);
		mirror.note_command(c);
		kinds_sent[c.kind]++;
		@(negedge clk);
	endtask

	task automatic do_op(logic [1:0] kind, logic [VALUE_W-1:0] value);
		cmd_t c;
		c.kind = kind;
		c.value = value;
		send_cmd(c);
	endtask

	task automatic write_order(bit smallest);
		cfg_valid = 1'b1;
		cfg_data = smallest;
		do
			@(posedge clk);
		while (!cfg_ready);
		mirror.set_order(smallest);
		order_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Configuration changes only once every reply is in and the block has dropped busy.
	task automatic wait_idle();
		start = 1'b0;
		while (mirror.due_results.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Values lean toward a few small numbers, so duplicates and removes of equal
	// entries happen often, and toward the corners of the unsigned range.
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 25)
			return $urandom_range(15);
		if (r < 35) begin
			case ($urandom_range(3))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return 32'h7fff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_kind(episode_t ep);
		int unsigned r;
		r = $urandom_range(99);
		case (ep)
			EP_FILL: return r < 85 ? K_PUSH : r < 92 ? K_POP : r < 98 ? K_REMOVE : K_IGNORED;
			EP_DRAIN: return r < 15 ? K_PUSH : r < 70 ? K_POP : r < 97 ? K_REMOVE : K_IGNORED;
			default: return r < 40 ? K_PUSH : r < 68 ? K_POP : r < 95 ? K_REMOVE : K_IGNORED;
		endcase
	endfunction

	initial begin
		int unsigned issued;
		int unsigned ep_len;
		episode_t ep;
		logic [1:0] kind;
		logic [VALUE_W-1:0] value;

		mirror = new();
		cycles = 0;
		gap_pct = 27;
		order_writes = 0;
		foreach (kinds_sent[i])
			kinds_sent[i] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, largest on top: the empty-queue cases first, then a small
		// heap with duplicates, a remove that drops the last slot, a remove that pulls
		// the last entry into an inner slot, and pops down past empty.
		write_order(ORDER_LARGEST);
		do_op(K_POP, '0);
		do_op(K_REMOVE, 32'd5);
		do_op(K_IGNORED, '1);
		do_op(K_PUSH, '0);
		do_op(K_PUSH, '1);
		do_op(K_PUSH, 32'd7);
		do_op(K_PUSH, 32'd7);
		do_op(K_REMOVE, 32'd123);
		do_op(K_REMOVE, '0);
		do_op(K_IGNORED, '0);
		do_op(K_REMOVE, 32'd7);
		do_op(K_POP, '0);
		do_op(K_POP, '0);
		do_op(K_POP, '0);

		// Same idea with the smallest value on top.
		wait_idle();
		write_order(ORDER_SMALLEST);
		do_op(K_PUSH, 32'd5);
		do_op(K_PUSH, '1);
		do_op(K_PUSH, '0);
		do_op(K_PUSH, 32'h8000_0000);
		do_op(K_REMOVE, '1);
		repeat (4) do_op(K_POP, '0);

		// Random part, in episodes that each start with an order write. Fill episodes
		// run the heap into its full limit, drain episodes down to empty, and mixed
		// ones wander in between. Sometimes the same order is rewritten, and the
		// order may flip while entries are stored. One stretch runs without gaps.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			wait_idle();
			write_order(($urandom_range(3) == 0) ? mirror.smallest_on_top
				: !mirror.smallest_on_top);
			ep = episode_t'($urandom_range(2));
			ep_len = $urandom_range(40, 160);
			if (ep_len > RANDOM_ITEMS - issued)
				ep_len = RANDOM_ITEMS - issued;
			gap_pct = (issued >= 500 && issued < 800) ? 0 : 27;
			repeat (ep_len) begin
				kind = pick_kind(ep);
				if (kind == K_REMOVE && mirror.fill > 0 && $urandom_range(99) < 70)
					value = mirror.any_stored();
				else
					value = pick_value();
				do_op(kind, value);
				issued++;
			end
		end

		// Let the last replies come in and give the block time to show anything stray.
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mirror.due_results.size() != 0)
			mirror.flag($sformatf("%0d expected results never arrived",
				mirror.due_results.size()));

		$display("Sent %0d push, %0d pop, %0d remove, %0d ignored-kind commands,",
			kinds_sent[K_PUSH], kinds_sent[K_POP], kinds_sent[K_REMOVE],
			kinds_sent[K_IGNORED]);
		$display("%0d order writes; peak fill %0d of %0d.", order_writes,
			mirror.peak_fill, HEAP_DEPTH);
		$display("Replies: %0d ok, %0d full, %0d empty, %0d not found; %0d problems in %0d cycles.",
			mirror.status_seen[ST_OK], mirror.status_seen[ST_FULL],
			mirror.status_seen[ST_EMPTY], mirror.status_seen[ST_NOT_FOUND],
			mirror.failures, cycles);
		if (mirror.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bhpq_pkg.sv
rtl/bhpq_level_cell.sv
rtl/binary_heap_priority_queue_top.sv
bench/testbench.sv
